@@ src/sewr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sewr_pkg: shared types and constants
// Sizes, register indexes and the multiply-accumulate command for the echo.
// ----------------------------------------------------------------------------
package sewr_pkg;

	localparam int DELAY_DEPTH = 131072;
	localparam int AW          = $clog2(DELAY_DEPTH);
	localparam int LEN_W       = AW + 1;
	localparam int FADE_LEN    = 9600;
	localparam bit DIRECT_MODE = 1'b0;

	localparam logic [17:0] ONE_Q16  = 18'd65536;
	localparam logic [15:0] FB_MAX   = 16'd65024;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_PAN    = 3'd0;
	localparam logic [2:0] REG_LDELAY = 3'd1;
	localparam logic [2:0] REG_RDELAY = 3'd2;
	localparam logic [2:0] REG_CMIX   = 3'd3;
	localparam logic [2:0] REG_FB     = 3'd4;
	localparam logic [2:0] REG_DAMP   = 3'd5;
	localparam logic [2:0] REG_REV    = 3'd6;
	localparam logic [2:0] REG_SWELL  = 3'd7;

	localparam int ACC_W = 64;
	localparam int OP_W  = 20;

	// Accumulator preload: zero, or the rounding half for a shift by 16 or 32
	typedef enum logic [1:0] {
		INIT_ZERO = 2'd0,
		INIT_H15  = 2'd1,
		INIT_H31  = 2'd2
	} init_t;

	typedef struct packed {
		logic                   en;
		logic                   load;
		init_t                  init;
		logic                   sh16;
		logic signed [OP_W-1:0] x;
		logic signed [OP_W-1:0] y;
	} mac_op_t;

endpackage

@@ src/stereo_echo_with_reverse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_echo_with_reverse: stereo feedback delay echo with reverse echo
// Two 131072-word delay lines, cross mix, feedback, damping, reverse swell.
// ----------------------------------------------------------------------------
// One stereo item is worked by a single shared multiply-accumulate unit under
// a sequencer, left channel first, then right. The idle state accepts the
// item and the cross mix follows; each channel then runs its normal steps,
// and in reverse mode adds the reverse word alone when the swell phase is
// above pi, or the swell window otherwise. The steps are set by the one
// multiplier and the one read port of each delay line. The input stalls for
// the whole item; a finished result waits in the output register, so the next
// item can start while it is not yet taken. After reset and after every write
// of left_delay or right_delay the block runs a clearing pass over both delay
// lines and takes no item meanwhile; configuration writes belong between
// items.
// ----------------------------------------------------------------------------
module stereo_echo_with_reverse
	import sewr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] left_in,
	input  logic signed [15:0] right_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [17:0]        cfg_data
);

	typedef enum logic [30:0] {
		S_IDLE = 31'd1 << 0,
		S_CLR  = 31'd1 << 1,
		S_RD   = 31'd1 << 2,
		S_M2   = 31'd1 << 3,
		S_M3   = 31'd1 << 4,
		S_M4   = 31'd1 << 5,
		S_M5   = 31'd1 << 6,
		S_C1   = 31'd1 << 7,
		S_C2   = 31'd1 << 8,
		S_C3   = 31'd1 << 9,
		S_C4   = 31'd1 << 10,
		S_C5   = 31'd1 << 11,
		S_V1   = 31'd1 << 12,
		S_V2   = 31'd1 << 13,
		S_V3   = 31'd1 << 14,
		S_N1   = 31'd1 << 15,
		S_N2   = 31'd1 << 16,
		S_N3   = 31'd1 << 17,
		S_W1   = 31'd1 << 18,
		S_W2   = 31'd1 << 19,
		S_W3   = 31'd1 << 20,
		S_W4   = 31'd1 << 21,
		S_W5   = 31'd1 << 22,
		S_W6   = 31'd1 << 23,
		S_W7   = 31'd1 << 24,
		S_W8   = 31'd1 << 25,
		S_W9   = 31'd1 << 26,
		S_W10  = 31'd1 << 27,
		S_W11  = 31'd1 << 28,
		S_W12  = 31'd1 << 29,
		S_FIN  = 31'd1 << 30
	} state_t;

	function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
		if (v > 24'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -24'sd32768) begin
			return -16'sd32768;
		end
		return 16'(v);
	endfunction

	function automatic logic [LEN_W-1:0] active_len(input logic [17:0] r);
		if (r == '0) begin
			return LEN_W'(1);
		end else if (r > 18'(DELAY_DEPTH)) begin
			return LEN_W'(DELAY_DEPTH);
		end
		return LEN_W'(r);
	endfunction

	function automatic logic [16:0] cap17(input logic [16:0] v);
		return (v > 17'd65536) ? 17'd65536 : v;
	endfunction

	// Configuration registers (raw values, capped where used)
	logic [16:0] pan_q, cmix_q, damp_q, rev_q;
	logic [17:0] ldel_q, rdel_q, swell_q;
	logic [15:0] fb_q;

	// Control state
	state_t               state_q;
	logic                 ch_q;
	logic [LEN_W-1:0]     lclr_q, rclr_q;
	logic [AW-1:0]        cnt_q;
	logic [AW-1:0]        lpos_q, rpos_q;
	logic signed [15:0]   lprev_q, rprev_q;
	logic                 out_valid_q;

	// Datapath registers
	logic signed [15:0]   lin_q, rin_q;
	logic signed [15:0]   a_q, b_q;
	logic signed [17:0]   lm_q, rm_q;
	logic signed [17:0]   fbt_q, loop_q;
	logic signed [15:0]   nv_q;
	logic signed [23:0]   outv_q;
	logic signed [15:0]   ra_q, rb_q;
	logic [16:0]          t_q, t2_q, w_q;
	logic signed [17:0]   bh_q;
	logic signed [15:0]   lo_q, lout_q, rout_q;

	// Derived values
	logic [LEN_W-1:0]     dl_c, dr_c, d_c, nl_c, nr_c;
	logic [16:0]          pan_c, cmix_c, damp_c, rev_c;
	logic [16:0]          cmixn_c, dampn_c, revn_c, gain_c, wn_c;
	logic [15:0]          fb_c;
	logic [AW-1:0]        lfix_c, rfix_c, k_c, rvk_c, dist_c, knext_c;
	logic [LEN_W:0]       rvf_c, rvf2_c;
	logic                 rvf_ok_c;
	logic [LEN_W-1:0]     kinc_c;
	logic signed [17:0]   mix_c, loop_c, path_c, bh_c;
	logic signed [15:0]   in_c, prev_c, nv_c, rd_c;
	logic [16:0]          q_c, t2_c, s_c, w_c;
	logic [18:0]          wraw_c;
	logic                 fin_go;
	logic                 accept;

	// Memories and shared unit
	logic                 we_l, we_r;
	logic [AW-1:0]        waddr_l, waddr_r, raddr_l, raddr_r;
	logic signed [15:0]   wdata_l, wdata_r, rdata_l, rdata_r;
	mac_op_t              op;
	logic signed [ACC_W-1:0] acc;

	sewr_store u_lstore (
		.clk   (clk),
		.we    (we_l),
		.waddr (waddr_l),
		.wdata (wdata_l),
		.raddr (raddr_l),
		.rdata (rdata_l)
	);

	sewr_store u_rstore (
		.clk   (clk),
		.we    (we_r),
		.waddr (waddr_r),
		.wdata (wdata_r),
		.raddr (raddr_r),
		.rdata (rdata_r)
	);

	sewr_mac u_mac (
		.clk (clk),
		.op  (op),
		.acc (acc)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign left_out  = lout_q;
	assign right_out = rout_q;

	// Hold the right channel's finish until the output register is free
	assign fin_go = !(ch_q && out_valid_q && out_stall);

	always_comb begin
		dl_c    = active_len(ldel_q);
		dr_c    = active_len(rdel_q);
		nl_c    = active_len((cfg_index == REG_LDELAY) ? cfg_data : ldel_q);
		nr_c    = active_len((cfg_index == REG_RDELAY) ? cfg_data : rdel_q);
		pan_c   = cap17(pan_q);
		cmix_c  = cap17(cmix_q);
		damp_c  = cap17(damp_q);
		rev_c   = cap17(rev_q);
		fb_c    = (fb_q > FB_MAX) ? FB_MAX : fb_q;
		cmixn_c = 17'(ONE_Q16 - 18'(cmix_c));
		dampn_c = 17'(ONE_Q16 - 18'(damp_c));
		revn_c  = 17'(ONE_Q16 - 18'(rev_c));

		// A position at or past the active length restarts at zero
		lfix_c = (LEN_W'(lpos_q) >= dl_c) ? '0 : lpos_q;
		rfix_c = (LEN_W'(rpos_q) >= dr_c) ? '0 : rpos_q;

		k_c    = ch_q ? rpos_q : lpos_q;
		d_c    = ch_q ? dr_c : dl_c;
		mix_c  = ch_q ? rm_q : lm_q;
		in_c   = ch_q ? rin_q : lin_q;
		prev_c = ch_q ? rprev_q : lprev_q;
		gain_c = ch_q ? 17'(ONE_Q16 - 18'(pan_c)) : pan_c;
		rd_c   = ch_q ? rdata_r : rdata_l;

		loop_c = 18'(acc[33:16]) + fbt_q;
		path_c = DIRECT_MODE ? fbt_q : loop_q;
		nv_c   = sat16(24'(acc[39:16]));

		// Reverse read addresses
		rvk_c    = AW'(d_c - LEN_W'(1) - LEN_W'(k_c));
		dist_c   = (k_c > rvk_c) ? (k_c - rvk_c) : (rvk_c - k_c);
		rvf_c    = (LEN_W+1)'(d_c) + (LEN_W+1)'(FADE_LEN) - (LEN_W+1)'(k_c);
		rvf2_c   = (rvf_c > (LEN_W+1)'(d_c)) ? (rvf_c - (LEN_W+1)'(d_c)) : rvf_c;
		rvf_ok_c = (rvf2_c < (LEN_W+1)'(d_c));

		kinc_c  = LEN_W'(k_c) + LEN_W'(1);
		knext_c = (kinc_c >= d_c) ? '0 : AW'(kinc_c);

		// Swell polynomial terms
		t2_c = acc[32:16];
		s_c  = acc[32:16];
		unique case (state_q)
			S_W3:    q_c = 17'(18'd5223 - 18'(acc[33:16]));
			S_W4:    q_c = 17'(18'd42334 - 18'(acc[33:16]));
			default: q_c = 17'(18'd102944 - 18'(acc[33:16]));
		endcase
		wraw_c = acc[34:16];
		w_c    = (wraw_c > 19'd65536) ? 17'd65536 : 17'(wraw_c);
		wn_c   = 17'(ONE_Q16 - 18'(w_q));
		bh_c   = 18'(acc[33:16]);
	end

	// Memory ports
	always_comb begin
		raddr_l = lfix_c;
		raddr_r = rfix_c;
		if (state_q == S_V1) begin
			if (ch_q) raddr_r = rvk_c;
			else      raddr_l = rvk_c;
		end else if (state_q == S_V2) begin
			if (ch_q) raddr_r = AW'(rvf2_c);
			else      raddr_l = AW'(rvf2_c);
		end

		if (state_q == S_CLR) begin
			we_l    = (LEN_W'(cnt_q) >= lclr_q);
			we_r    = (LEN_W'(cnt_q) >= rclr_q);
			waddr_l = cnt_q;
			waddr_r = cnt_q;
			wdata_l = '0;
			wdata_r = '0;
		end else begin
			we_l    = (state_q == S_FIN) && fin_go && !ch_q;
			we_r    = (state_q == S_FIN) && fin_go && ch_q;
			waddr_l = lpos_q;
			waddr_r = rpos_q;
			wdata_l = nv_q;
			wdata_r = nv_q;
		end
	end

	// Command for the shared multiply-accumulate unit
	always_comb begin
		op      = '0;
		op.init = INIT_ZERO;
		unique case (state_q)
			S_RD: begin
				op = '{1'b1, 1'b1, INIT_H15, 1'b0, OP_W'(rdata_l), OP_W'(cmixn_c)};
			end
			S_M2: begin
				op = '{1'b1, 1'b0, INIT_ZERO, 1'b0, OP_W'(b_q), OP_W'(cmix_c)};
			end
			S_M3: begin
				op = '{1'b1, 1'b1, INIT_H15, 1'b0, OP_W'(b_q), OP_W'(cmixn_c)};
			end
			S_M4: begin
				op = '{1'b1, 1'b0, INIT_ZERO, 1'b0, OP_W'(a_q), OP_W'(cmix_c)};
			end
			S_C1: begin
				op = '{1'b1, 1'b1, INIT_H15, 1'b0, OP_W'(mix_c), OP_W'(fb_c)};
			end
			S_C2: begin
				op = '{1'b1, 1'b1, INIT_H15, 1'b0, OP_W'(in_c), OP_W'(gain_c)};
			end
			S_C3: begin
				op = '{1'b1, 1'b1, INIT_H15, 1'b0, OP_W'(loop_c), OP_W'(damp_c)};
			end
			S_C4: begin
				op = '{1'b1, 1'b0, INIT_ZERO, 1'b0, OP_W'(prev_c), OP_W'(dampn_c)};
			end
			S_V1: begin
				op = '{1'b1, 1'b1, INIT_ZERO, 1'b0, OP_W'(dist_c), OP_W'(swell_q)};
			end
			S_N1: begin
				op = '{1'b1, 1'b1, INIT_H15, 1'b0, OP_W'(ra_q), OP_W'(rev_c)};
			end
			S_N2: begin
				op = '{1'b1, 1'b0, INIT_ZERO, 1'b0, OP_W'(path_c), OP_W'(revn_c)};
			end
			S_W1: begin
				op = '{1'b1, 1'b1, INIT_ZERO, 1'b0, OP_W'(t_q), OP_W'(t_q)};
			end
			S_W2: begin
				op = '{1'b1, 1'b1, INIT_ZERO, 1'b0, OP_W'(17'd307), OP_W'(t2_c)};
			end
			S_W3, S_W4: begin
				op = '{1'b1, 1'b1, INIT_ZERO, 1'b0, OP_W'(q_c), OP_W'(t2_q)};
			end
			S_W5: begin
				op = '{1'b1, 1'b1, INIT_ZERO, 1'b0, OP_W'(q_c), OP_W'(t_q)};
			end
			S_W6: begin
				op = '{1'b1, 1'b1, INIT_H15, 1'b0, OP_W'(s_c), OP_W'(s_c)};
			end
			S_W7: begin
				op = '{1'b1, 1'b1, INIT_ZERO, 1'b0, OP_W'(ra_q), OP_W'(w_c)};
			end
			S_W8: begin
				op = '{1'b1, 1'b0, INIT_ZERO, 1'b0, OP_W'(rb_q), OP_W'(wn_c)};
			end
			S_W9: begin
				op = '{1'b1, 1'b1, INIT_H31, 1'b0, OP_W'(rev_c), OP_W'(acc[15:0])};
			end
			S_W10: begin
				op = '{1'b1, 1'b0, INIT_ZERO, 1'b1, OP_W'(rev_c), OP_W'(bh_q)};
			end
			S_W11: begin
				op = '{1'b1, 1'b0, INIT_ZERO, 1'b1, OP_W'(path_c), OP_W'(revn_c)};
			end
			default: begin
				op = '0;
			end
		endcase
	end

	// Sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ch_q        <= 1'b0;
			lclr_q      <= '0;
			rclr_q      <= '0;
			cnt_q       <= '0;
			lpos_q      <= '0;
			rpos_q      <= '0;
			lprev_q     <= '0;
			rprev_q     <= '0;
			out_valid_q <= 1'b0;
			pan_q       <= 17'd33026;
			ldel_q      <= 18'd2880;
			rdel_q      <= 18'd2880;
			cmix_q      <= 17'd15480;
			fb_q        <= 16'd30208;
			damp_q      <= 17'd65536;
			rev_q       <= 17'd0;
			swell_q     <= 18'd170;
		end else begin
			// Drop the taken result unless the next one replaces it now
			if (out_valid_q && !out_stall && !(state_q == S_FIN && ch_q)) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we && (cfg_index == REG_LDELAY || cfg_index == REG_RDELAY)) begin
				// A new delay length restarts both lines and clears the tail;
				// a pass still running keeps clearing from the lower start
				lpos_q  <= '0;
				rpos_q  <= '0;
				lprev_q <= '0;
				rprev_q <= '0;
				cnt_q   <= '0;
				lclr_q  <= (state_q == S_CLR && lclr_q < nl_c) ? lclr_q : nl_c;
				rclr_q  <= (state_q == S_CLR && rclr_q < nr_c) ? rclr_q : nr_c;
				state_q <= S_CLR;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept) begin
							lpos_q  <= lfix_c;
							rpos_q  <= rfix_c;
							ch_q    <= 1'b0;
							state_q <= S_RD;
						end
					end
					S_CLR: begin
						cnt_q <= cnt_q + AW'(1);
						if (cnt_q == AW'(DELAY_DEPTH - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_RD:  state_q <= S_M2;
					S_M2:  state_q <= S_M3;
					S_M3:  state_q <= S_M4;
					S_M4:  state_q <= S_M5;
					S_M5:  state_q <= S_C1;
					S_C1:  state_q <= S_C2;
					S_C2:  state_q <= S_C3;
					S_C3:  state_q <= S_C4;
					S_C4:  state_q <= S_C5;
					S_C5: begin
						if (ch_q) rprev_q <= nv_c;
						else      lprev_q <= nv_c;
						state_q <= (rev_c != '0) ? S_V1 : S_FIN;
					end
					S_V1:  state_q <= S_V2;
					S_V2:  state_q <= S_V3;
					S_V3: begin
						// Phase above pi: reverse word alone, no swell
						state_q <= (acc > ACC_W'(65536)) ? S_N1 : S_W1;
					end
					S_N1:  state_q <= S_N2;
					S_N2:  state_q <= S_N3;
					S_N3:  state_q <= S_FIN;
					S_W1:  state_q <= S_W2;
					S_W2:  state_q <= S_W3;
					S_W3:  state_q <= S_W4;
					S_W4:  state_q <= S_W5;
					S_W5:  state_q <= S_W6;
					S_W6:  state_q <= S_W7;
					S_W7:  state_q <= S_W8;
					S_W8:  state_q <= S_W9;
					S_W9:  state_q <= S_W10;
					S_W10: state_q <= S_W11;
					S_W11: state_q <= S_W12;
					S_W12: state_q <= S_FIN;
					S_FIN: begin
						if (fin_go) begin
							if (ch_q) begin
								rpos_q      <= knext_c;
								out_valid_q <= 1'b1;
								state_q     <= S_IDLE;
							end else begin
								lpos_q  <= knext_c;
								ch_q    <= 1'b1;
								state_q <= S_C1;
							end
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end

			if (cfg_we) begin
				unique case (cfg_index)
					REG_PAN:    pan_q   <= cfg_data[16:0];
					REG_LDELAY: ldel_q  <= cfg_data;
					REG_RDELAY: rdel_q  <= cfg_data;
					REG_CMIX:   cmix_q  <= cfg_data[16:0];
					REG_FB:     fb_q    <= cfg_data[15:0];
					REG_DAMP:   damp_q  <= cfg_data[16:0];
					REG_REV:    rev_q   <= cfg_data[16:0];
					REG_SWELL:  swell_q <= cfg_data;
					default:    pan_q   <= pan_q;
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			lin_q <= left_in;
			rin_q <= right_in;
		end
		unique case (state_q)
			S_RD: begin
				a_q <= rdata_l;
				b_q <= rdata_r;
			end
			S_M3:  lm_q   <= 18'(acc[33:16]);
			S_M5:  rm_q   <= 18'(acc[33:16]);
			S_C2:  fbt_q  <= -18'(acc[33:16]);
			S_C3:  loop_q <= loop_c;
			S_C5: begin
				nv_q   <= nv_c;
				outv_q <= 24'(path_c);
			end
			S_V2:  ra_q <= rd_c;
			S_V3: begin
				rb_q <= rvf_ok_c ? rd_c : 16'sd0;
				t_q  <= acc[16:0];
			end
			S_N3:  outv_q <= 24'(acc[39:16]);
			S_W2:  t2_q   <= t2_c;
			S_W7:  w_q    <= w_c;
			S_W9:  bh_q   <= bh_c;
			S_W12: outv_q <= 24'(acc[55:32]);
			S_FIN: begin
				if (fin_go) begin
					if (ch_q) begin
						lout_q <= lo_q;
						rout_q <= sat16(outv_q);
					end else begin
						lo_q <= sat16(outv_q);
					end
				end
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
	end

endmodule

@@ src/sewr_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sewr_store: one delay line memory
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module sewr_store
	import sewr_pkg::*;
(
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic signed [15:0]  wdata,
	input  logic [AW-1:0]       raddr,
	output logic signed [15:0]  rdata
);

	logic signed [15:0] mem [DELAY_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/sewr_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sewr_mac: shared multiply-accumulate unit
// One signed 20x20 product per enabled cycle, optionally shifted up by 16,
// added to the accumulator or to a preload of zero or a rounding half.
// ----------------------------------------------------------------------------
module sewr_mac
	import sewr_pkg::*;
(
	input  logic                    clk,
	input  mac_op_t                 op,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [2*OP_W-1:0] prod;
	logic signed [ACC_W-1:0]  prod_x;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W-1:0]  acc_q;

	always_comb begin
		prod   = op.x * op.y;
		prod_x = ACC_W'(prod);
		if (op.sh16) begin
			prod_x = prod_x <<< 16;
		end
		base = acc_q;
		if (op.load) begin
			unique case (op.init)
				INIT_ZERO: base = '0;
				INIT_H15:  base = ACC_W'(64'sd32768);
				INIT_H31:  base = ACC_W'(64'sd2147483648);
				default:   base = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op.en) begin
			acc_q <= base + prod_x;
		end
	end

	assign acc = acc_q;

endmodule
